FILE: rtl/core/chbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body extractor package
// Shared result codes, parse phases and the result bundle of the parser.
// ----------------------------------------------------------------------------
package chbe_pkg;

   localparam int LEN_W = 32;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_BAD_HEX  = 3'd1,
      ERR_OVERFLOW = 3'd2,
      ERR_NO_CRLF  = 3'd3,
      ERR_EARLY    = 3'd4
   } err_type;

   typedef enum logic [7:0] {
      PH_HEADER    = 8'b0000_0001,
      PH_SIZE      = 8'b0000_0010,
      PH_SIZE_LF   = 8'b0000_0100,
      PH_DATA      = 8'b0000_1000,
      PH_DATA_CRLF = 8'b0001_0000,
      PH_PLAIN     = 8'b0010_0000,
      PH_DONE      = 8'b0100_0000,
      PH_ERROR     = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic             valid;
      logic [7:0]       body_byte;
      kind_type         kind;
      err_type          code;
      logic [LEN_W-1:0] body_length;
   } result_type;

endpackage

FILE: rtl/core/chbe_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body extractor parser
// Holds the parse state and works out the result of one request byte.
// ----------------------------------------------------------------------------
module chbe_parser #(
   parameter int SIZE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                msg_start,
   input  logic                end_of_message,
   input  logic                chunked_mode,
   output chbe_pkg::result_type result
);
   import chbe_pkg::*;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   phase_type            phase_ff, phase_in, ph;
   logic [1:0]           crlf_ff, crlf_in, crlf;
   logic [SIZE_BITS-1:0] acc_ff, acc_in, acc;
   logic                 seen_ff, seen_in, seen;
   logic [SIZE_BITS-1:0] rem_ff, rem_in, rem;
   logic [LEN_W-1:0]     count_ff, count_in, count;
   logic [4:0]           hex;
   logic                 finished;
   err_type              err;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   always_comb begin
      ph    = msg_start ? PH_HEADER : phase_ff;
      crlf  = msg_start ? 2'd0 : crlf_ff;
      acc   = msg_start ? '0 : acc_ff;
      seen  = msg_start ? 1'b0 : seen_ff;
      rem   = msg_start ? '0 : rem_ff;
      count = msg_start ? '0 : count_ff;

      phase_in = ph;
      crlf_in  = crlf;
      acc_in   = acc;
      seen_in  = seen;
      rem_in   = rem;
      count_in = count;
      hex      = hex_decode(data_byte);
      err      = ERR_NONE;
      finished = 1'b0;
      result   = '0;

      unique case (ph)
         PH_HEADER: begin
            if (crlf == 2'd3 && data_byte == CHAR_LF) begin
               crlf_in = 2'd0;
               if (chunked_mode) begin
                  phase_in = PH_SIZE;
                  acc_in   = '0;
                  seen_in  = 1'b0;
               end else begin
                  phase_in = PH_PLAIN;
               end
            end else if (!crlf[0] && data_byte == CHAR_CR) begin
               crlf_in = crlf + 2'd1;
            end else if (crlf[0] && data_byte == CHAR_LF) begin
               crlf_in = crlf + 2'd1;
            end else begin
               crlf_in = (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
            end
            if (end_of_message) begin
               if (phase_in == PH_PLAIN) begin
                  phase_in           = PH_DONE;
                  finished           = 1'b1;
                  result.valid       = 1'b1;
                  result.kind        = KIND_END;
                  result.body_length = count;
               end else begin
                  err = ERR_EARLY;
               end
            end
         end
         PH_SIZE: begin
            if (data_byte == CHAR_CR) begin
               if (!seen) begin
                  err = ERR_BAD_HEX;
               end else begin
                  phase_in = PH_SIZE_LF;
               end
            end else if (!hex[4]) begin
               err = ERR_BAD_HEX;
            end else if (acc[SIZE_BITS-1 -: 4] != 4'd0) begin
               err = ERR_OVERFLOW;
            end else begin
               acc_in  = {acc[SIZE_BITS-5:0], hex[3:0]};
               seen_in = 1'b1;
            end
         end
         PH_SIZE_LF: begin
            if (data_byte != CHAR_LF) begin
               err = ERR_NO_CRLF;
            end else if (acc == '0) begin
               phase_in = PH_DATA_CRLF;
               crlf_in  = 2'd0;
            end else begin
               phase_in = PH_DATA;
               rem_in   = acc;
            end
         end
         PH_DATA: begin
            count_in           = (count == LEN_MAX) ? count : count + LEN_W'(1);
            result.valid       = 1'b1;
            result.body_byte   = data_byte;
            result.kind        = KIND_DATA;
            result.body_length = count_in;
            rem_in             = rem - SIZE_BITS'(1);
            if (rem_in == '0) begin
               phase_in = PH_DATA_CRLF;
               crlf_in  = 2'd0;
            end
         end
         PH_DATA_CRLF: begin
            if (crlf == 2'd0) begin
               if (data_byte == CHAR_CR) begin
                  crlf_in = 2'd1;
               end else begin
                  err = ERR_NO_CRLF;
               end
            end else if (data_byte != CHAR_LF) begin
               err = ERR_NO_CRLF;
            end else if (acc == '0) begin
               phase_in           = PH_DONE;
               finished           = 1'b1;
               result.valid       = 1'b1;
               result.kind        = KIND_END;
               result.body_length = count;
            end else begin
               phase_in = PH_SIZE;
               crlf_in  = 2'd0;
               acc_in   = '0;
               seen_in  = 1'b0;
            end
         end
         PH_PLAIN: begin
            count_in           = (count == LEN_MAX) ? count : count + LEN_W'(1);
            finished           = 1'b1;
            result.valid       = 1'b1;
            result.body_byte   = data_byte;
            result.kind        = KIND_DATA;
            result.body_length = count_in;
            if (end_of_message) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
            finished = 1'b1;
         end
      endcase

      if (!finished) begin
         if (err == ERR_NONE && end_of_message) begin
            err = ERR_EARLY;
         end
         if (err != ERR_NONE) begin
            phase_in           = PH_ERROR;
            result.valid       = 1'b1;
            result.body_byte   = 8'd0;
            result.kind        = KIND_ERR;
            result.code        = err;
            result.body_length = count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         crlf_ff  <= 2'd0;
         acc_ff   <= '0;
         seen_ff  <= 1'b0;
         rem_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         crlf_ff  <= crlf_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         rem_ff   <= rem_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/http_chunked_body_extractor_top.sv
`timescale 1ns / 1ps
// A request byte is held in the input register until the result register can
// take its result. Throughput: one request byte per cycle while results are not
// stalled, set by the single parse step between the input and result registers.
// Reset: synchronous and active high; it clears the parse state, both pipeline
// valid flags and the chunked mode register.
// ----------------------------------------------------------------------------
// HTTP chunked body extractor
// Skips the response header, then passes plain or chunk-decoded body bytes
// and reports the end of the body or a parse error.
// ----------------------------------------------------------------------------
module http_chunked_body_extractor_top #(
   parameter int SIZE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,  // [0] msg_start
   input  logic        req_tlast,  // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [7:0] body_byte, [10:8] error_code,
                                   // [42:11] body_length, [47:43] zero
   output logic [1:0]  rsp_tuser   // [1:0] result_kind
);
   import chbe_pkg::*;

   logic       mode_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       in_last_ff;
   logic       advance;
   result_type result;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? result.valid : (out_valid_ff && !rsp_tready);

   chbe_parser #(
      .SIZE_BITS(SIZE_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .data_byte     (in_byte_ff),
      .msg_start     (in_start_ff),
      .end_of_message(in_last_ff),
      .chunked_mode  (mode_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            mode_ff <= csr_wdata;
         end
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
      if (advance && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.body_length, out_ff.code, out_ff.body_byte};
   assign rsp_tuser  = out_ff.kind;

endmodule

FILE: rtl/core/chbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body extractor port checker
// Watches the top-level ports for result channel and encoding rules.
// ----------------------------------------------------------------------------
module chbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import chbe_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result changed or dropped.");

   a_reset_clears: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == KIND_DATA || rsp_tuser == KIND_END || rsp_tuser == KIND_ERR)
      else $error("Illegal result kind.");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DATA |-> rsp_tdata[7:0] == 8'd0)
      else $error("Body byte set on a non-data result.");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_ERR |-> rsp_tdata[10:8] == ERR_NONE &&
      rsp_tdata[47:43] == 5'd0)
      else $error("Error code set on a non-error result.");

endmodule

bind http_chunked_body_extractor_top chbe_checker u_chbe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

FILE: tb/http_chunked_body_extractor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP chunked body extractor testbench
// Sends plain and chunked responses through the request stream, including
// truncated and malformed ones. A behavioral parser predicts each result, and
// the result stream is checked with and without random idling on both sides.
// ----------------------------------------------------------------------------
module http_chunked_body_extractor_top_tb;
   import chbe_pkg::*;

   localparam logic [7:0] CR = 8'h0D;
   localparam logic [7:0] LF = 8'h0A;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       fin;
   } stream_req_type;

   typedef struct packed {
      logic [7:0]       body_byte;
      kind_type         kind;
      err_type          code;
      logic [LEN_W-1:0] length;
   } body_result_type;

   typedef enum int {
      FAULT_NONE,
      FAULT_BAD_DIGIT,
      FAULT_EMPTY_SIZE,
      FAULT_OVERFLOW,
      FAULT_SIZE_LF,
      FAULT_DATA_CRLF,
      FAULT_TRAILER,
      FAULT_EARLY_END,
      FAULT_CUT
   } fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;  // [7:0] data_byte
   logic        req_tuser = 1'b0;   // [0] msg_start
   logic        req_tlast = 1'b0;   // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;          // [7:0] body_byte, [10:8] error_code,
                                    // [42:11] body_length, [47:43] zero
   logic [1:0]  rsp_tuser;          // [1:0] result_kind

   stream_req_type  stream_reqs[$];
   stream_req_type  msg_bytes[$];
   body_result_type body_results_due[$];
   stream_req_type  req_now;
   bit              quiet = 1'b0;
   bit              start_next = 1'b0;
   int              fail_count = 0;

   logic        chunked_on = 1'b0;
   phase_type   ph = PH_HEADER;
   logic [1:0]  crlf_cnt = 2'd0;
   logic [31:0] size_acc = '0;
   logic [31:0] left_in_chunk = '0;
   logic [31:0] body_cnt = '0;
   logic        digit_seen = 1'b0;

   http_chunked_body_extractor_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + nib;
      return (chance(50) ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   function automatic logic [7:0] header_char();
      logic [7:0] b;
      b = 8'($urandom);
      return (b == LF) ? 8'h41 : b;
   endfunction

   function automatic logic [31:0] chunk_len(input bit big_ok);
      if (big_ok && chance(30)) return chance(30) ? 32'hFFFF_FFFF : $urandom;
      if (chance(88)) return $urandom_range(16, 1);
      return $urandom_range(300, 17);
   endfunction

   task automatic parse_byte(input stream_req_type r);
      body_result_type res;
      err_type         err;
      bit              emit;
      bit              closed;
      int              d;
      logic [7:0]      c;
      res = '0;
      err = ERR_NONE;
      emit = 1'b0;
      closed = 1'b0;
      c = r.data;
      if (r.first) begin
         ph = PH_HEADER;
         crlf_cnt = 2'd0;
         size_acc = '0;
         digit_seen = 1'b0;
         left_in_chunk = '0;
         body_cnt = '0;
      end
      case (ph)
         PH_HEADER: begin
            if (crlf_cnt == 2'd3 && c == LF) begin
               crlf_cnt = 2'd0;
               if (chunked_on) begin
                  ph = PH_SIZE;
                  size_acc = '0;
                  digit_seen = 1'b0;
               end else begin
                  ph = PH_PLAIN;
               end
            end else if (!crlf_cnt[0] && c == CR) begin
               crlf_cnt++;
            end else if (crlf_cnt[0] && c == LF) begin
               crlf_cnt++;
            end else begin
               crlf_cnt = (c == CR) ? 2'd1 : 2'd0;
            end
            if (r.fin) begin
               if (ph == PH_PLAIN) begin
                  ph = PH_DONE;
                  res.kind = KIND_END;
                  emit = 1'b1;
                  closed = 1'b1;
               end else begin
                  err = ERR_EARLY;
               end
            end
         end
         PH_SIZE: begin
            if (c == CR) begin
               if (!digit_seen) err = ERR_BAD_HEX;
               else ph = PH_SIZE_LF;
            end else begin
               d = nibble_of(c);
               if (d < 0) begin
                  err = ERR_BAD_HEX;
               end else if (size_acc[31:28] != 4'd0) begin
                  err = ERR_OVERFLOW;
               end else begin
                  size_acc = {size_acc[27:0], 4'(d)};
                  digit_seen = 1'b1;
               end
            end
         end
         PH_SIZE_LF: begin
            if (c != LF) begin
               err = ERR_NO_CRLF;
            end else if (size_acc == '0) begin
               ph = PH_DATA_CRLF;
               crlf_cnt = 2'd0;
            end else begin
               ph = PH_DATA;
               left_in_chunk = size_acc;
            end
         end
         PH_DATA: begin
            if (body_cnt != '1) body_cnt++;
            res.body_byte = c;
            res.kind = KIND_DATA;
            emit = 1'b1;
            left_in_chunk--;
            if (left_in_chunk == '0) begin
               ph = PH_DATA_CRLF;
               crlf_cnt = 2'd0;
            end
         end
         PH_DATA_CRLF: begin
            if (crlf_cnt == 2'd0) begin
               if (c == CR) crlf_cnt = 2'd1;
               else err = ERR_NO_CRLF;
            end else if (c != LF) begin
               err = ERR_NO_CRLF;
            end else if (size_acc == '0) begin
               ph = PH_DONE;
               res.kind = KIND_END;
               emit = 1'b1;
               closed = 1'b1;
            end else begin
               ph = PH_SIZE;
               crlf_cnt = 2'd0;
               size_acc = '0;
               digit_seen = 1'b0;
            end
         end
         PH_PLAIN: begin
            if (body_cnt != '1) body_cnt++;
            res.body_byte = c;
            res.kind = KIND_DATA;
            emit = 1'b1;
            closed = 1'b1;
            if (r.fin) ph = PH_DONE;
         end
         default: begin
            closed = 1'b1;
         end
      endcase
      if (!closed) begin
         if (err == ERR_NONE && r.fin) err = ERR_EARLY;
         if (err != ERR_NONE) begin
            ph = PH_ERROR;
            res.body_byte = 8'h00;
            res.kind = KIND_ERR;
            res.code = err;
            emit = 1'b1;
         end
      end
      if (emit) begin
         res.length = body_cnt;
         body_results_due.push_back(res);
      end
   endtask

   task automatic add_byte(input logic [7:0] b, input bit fin = 1'b0);
      stream_req_type r;
      r.data = b;
      r.first = start_next;
      r.fin = fin;
      start_next = 1'b0;
      msg_bytes.push_back(r);
   endtask

   task automatic add_crlf(input bit fin);
      add_byte(CR);
      add_byte(LF, fin);
   endtask

   task automatic add_header(input bit fin_at_end);
      start_next = 1'b1;
      if (chance(15)) begin
         add_crlf(1'b0);
      end else begin
         repeat ($urandom_range(3, 1)) begin
            repeat ($urandom_range(6, 1)) add_byte(header_char());
            add_crlf(1'b0);
         end
      end
      add_crlf(fin_at_end);
   endtask

   task automatic add_size(input logic [31:0] value);
      int n;
      n = 1;
      while (n < 8 && (value >> (4 * n)) != 0) n++;
      repeat (chance(25) ? $urandom_range(3, 1) : 0) add_byte("0");
      for (int i = n - 1; i >= 0; i--) add_byte(hex_char(value[4 * i +: 4]));
   endtask

   task automatic add_plain();
      int n;
      n = chance(10) ? 0 : $urandom_range(40, 1);
      add_header(n == 0);
      for (int i = 1; i <= n; i++) add_byte(8'($urandom), i == n);
   endtask

   task automatic add_chunked(input fault_type fault);
      int          chunks;
      int          at;
      logic [31:0] len;
      logic [7:0]  b;
      bit          big_ok;
      big_ok = (fault == FAULT_EARLY_END || fault == FAULT_CUT);
      add_header(1'b0);
      chunks = $urandom_range(4);
      at = (fault == FAULT_TRAILER) ? chunks : $urandom_range(chunks);
      for (int i = 0; i <= chunks; i++) begin
         len = (i == chunks) ? 32'd0 : chunk_len(big_ok);
         if (i == at) begin
            case (fault)
               FAULT_BAD_DIGIT: begin
                  repeat ($urandom_range(2)) add_byte(hex_char(4'($urandom)));
                  b = 8'($urandom);
                  if (nibble_of(b) >= 0 || b == CR) b = ";";
                  add_byte(b);
                  return;
               end
               FAULT_EMPTY_SIZE: begin
                  add_crlf(1'b0);
                  return;
               end
               FAULT_OVERFLOW: begin
                  repeat ($urandom_range(2)) add_byte("0");
                  add_byte(hex_char(4'($urandom_range(15, 1))));
                  repeat ($urandom_range(9, 8)) add_byte(hex_char(4'($urandom)));
                  return;
               end
               FAULT_SIZE_LF: begin
                  add_size(len);
                  add_byte(CR);
                  b = 8'($urandom);
                  add_byte((b == LF) ? CR : b);
                  return;
               end
               FAULT_DATA_CRLF, FAULT_TRAILER: begin
                  add_size(len);
                  add_crlf(1'b0);
                  repeat (len) add_byte(8'($urandom));
                  if (fault == FAULT_TRAILER) begin
                     add_byte("T");
                     add_byte(":");
                     add_byte("1");
                     add_crlf(1'b0);
                     add_crlf(1'b1);
                  end else if (chance(50)) begin
                     b = 8'($urandom);
                     add_byte((b == CR) ? LF : b);
                  end else begin
                     add_byte(CR);
                     b = 8'($urandom);
                     add_byte((b == LF) ? CR : b);
                  end
                  return;
               end
               default: ;
            endcase
         end
         add_size(len);
         add_crlf(1'b0);
         if (len > 300) begin
            repeat (24) add_byte(8'($urandom));
            return;
         end
         repeat (len) add_byte(8'($urandom));
         add_crlf(i == chunks);
      end
   endtask

   task automatic queue_message(input fault_type fault);
      int cut;
      if ((fault == FAULT_EARLY_END || fault == FAULT_CUT) && msg_bytes.size() > 1) begin
         cut = $urandom_range(msg_bytes.size() - 2);
         msg_bytes[cut].fin = (fault == FAULT_EARLY_END);
         while (msg_bytes.size() > cut + 1) void'(msg_bytes.pop_back());
      end
      while (msg_bytes.size() != 0) stream_reqs.push_back(msg_bytes.pop_front());
   endtask

   task automatic run_random(input bit chunked, input int target);
      fault_type fault;
      while (stream_reqs.size() < target) begin
         if (chunked) begin
            fault = chance(55) ? FAULT_NONE
                               : fault_type'($urandom_range(FAULT_CUT, FAULT_BAD_DIGIT));
            if (chance(90)) add_chunked(fault);
            else add_plain();
         end else begin
            fault = chance(80) ? FAULT_NONE : (chance(50) ? FAULT_EARLY_END : FAULT_CUT);
            if (chance(85)) add_plain();
            else add_chunked(FAULT_NONE);
         end
         queue_message(fault);
         if (chance(30)) begin
            repeat ($urandom_range(3, 1)) begin
               start_next = chance(5);
               add_byte(8'($urandom), chance(20));
            end
            queue_message(FAULT_NONE);
         end
      end
   endtask

   task automatic set_mode(input logic on);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= on;
      @(posedge clock);
      csr_wen <= 1'b0;
      chunked_on = on;
   endtask

   // The block may still be working on a request that gives no result, so a
   // short pause follows the drain.
   task automatic settle();
      do @(posedge clock);
      while (stream_reqs.size() != 0 || req_tvalid || body_results_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic note_failure(input string what, input body_result_type got,
                               input body_result_type want);
      fail_count++;
      if (fail_count <= 10)
         $display({"%0t %s: got byte %h kind %0d code %0d length %0d, ",
                   "expected byte %h kind %0d code %0d length %0d"},
                  $time, what, got.body_byte, got.kind, got.code, got.length,
                  want.body_byte, want.kind, want.code, want.length);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) parse_byte(req_now);
         if (!req_tvalid || req_tready) begin
            if (stream_reqs.size() != 0 && (quiet || !chance(13))) begin
               req_now = stream_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= req_now.data;
               req_tuser <= req_now.first;
               req_tlast <= req_now.fin;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      body_result_type seen;
      body_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.body_byte = rsp_tdata[7:0];
            seen.kind = kind_type'(rsp_tuser);
            seen.code = err_type'(rsp_tdata[10:8]);
            seen.length = rsp_tdata[42:11];
            if (body_results_due.size() == 0) begin
               note_failure("unexpected result", seen, '0);
            end else begin
               want = body_results_due.pop_front();
               if (seen !== want) note_failure("result mismatch", seen, want);
            end
         end
         rsp_tready <= quiet || !chance(13);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_mode(1'b0);
      start_next = 1'b1;
      add_crlf(1'b0);
      add_crlf(1'b1);
      start_next = 1'b1;
      add_crlf(1'b0);
      add_crlf(1'b0);
      add_byte(8'h00);
      add_byte(8'hFF, 1'b1);
      add_byte(8'hA5);
      start_next = 1'b1;
      add_byte("A", 1'b1);
      queue_message(FAULT_NONE);
      settle();

      set_mode(1'b1);
      start_next = 1'b1;
      add_crlf(1'b0);
      add_crlf(1'b0);
      add_byte("1");
      add_crlf(1'b0);
      add_byte(8'hFF);
      add_crlf(1'b0);
      add_byte("0");
      add_crlf(1'b0);
      add_crlf(1'b1);
      start_next = 1'b1;
      add_crlf(1'b0);
      add_crlf(1'b0);
      add_byte(";");
      queue_message(FAULT_NONE);
      settle();

      run_random(1'b1, 300);
      settle();
      run_random(1'b1, 300);
      settle();

      set_mode(1'b0);
      run_random(1'b0, 250);
      settle();

      set_mode(1'b1);
      quiet = 1'b1;
      run_random(1'b1, 300);
      settle();

      if (fail_count == 0) begin
         $display("http_chunked_body_extractor_top test passed");
      end else begin
         $display("http_chunked_body_extractor_top test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("http_chunked_body_extractor_top test failed");
      $finish;
   end

endmodule
